// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
// expects signals named clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SEDT_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// implication checked from one edge to the next
`define SEDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/sedt_pkg.sv =====
// shared types, register codes and constants of the sobel edge block
// no dependencies
`default_nettype none

package sedt_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 4'd0,
    REG_SKETCH_MODE  = 4'd1,
    REG_FRAME_WIDTH  = 4'd2,
    REG_FRAME_HEIGHT = 4'd3
  } reg_idx_t;

  // field widths of the streams
  localparam int PIX_W      = 32;
  localparam int OUT_COL_W  = 10;
  localparam int OUT_ROW_W  = 12;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 56;
  localparam int LUMA_W     = 8;
  localparam int SUM_W      = 18;

  // luma weights and reciprocal of 1000 (exact for sums up to 255000)
  localparam int LUMA_W_LO   = 299;
  localparam int LUMA_W_MID  = 587;
  localparam int LUMA_W_HI   = 114;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] LUMA_RECIP = 19'd268436;

  localparam logic [7:0] THR_DEFAULT = 8'd30;
  localparam logic [7:0] MAG_MAX     = 8'd255;

  localparam logic [PIX_W-1:0] PIX_OPAQUE = 32'hFF000000;
  localparam logic [PIX_W-1:0] PIX_WHITE  = 32'hFFFFFFFF;
  localparam logic [PIX_W-1:0] PIX_BLACK  = 32'h00000000;

  // one column of the 3x3 luma window
  typedef struct packed {
    logic [LUMA_W-1:0] top;
    logic [LUMA_W-1:0] mid;
    logic [LUMA_W-1:0] bot;
  } col_t;

  // one result request
  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [PIX_W-1:0]     pixel;
    logic                 done;
  } res_t;

  // L1 sobel magnitude over three columns, clamped to 255
  function automatic logic [7:0] sobel_mag(col_t l, col_t c, col_t r);
    logic [9:0]  gx_pos;
    logic [9:0]  gx_neg;
    logic [9:0]  gy_pos;
    logic [9:0]  gy_neg;
    logic [9:0]  ax;
    logic [9:0]  ay;
    logic [10:0] m;
    gx_pos = 10'(r.top) + {1'b0, r.mid, 1'b0} + 10'(r.bot);
    gx_neg = 10'(l.top) + {1'b0, l.mid, 1'b0} + 10'(l.bot);
    gy_pos = 10'(l.bot) + {1'b0, c.bot, 1'b0} + 10'(r.bot);
    gy_neg = 10'(l.top) + {1'b0, c.top, 1'b0} + 10'(r.top);
    ax = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    ay = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    m  = 11'(ax) + 11'(ay);
    return (m > 11'(MAG_MAX)) ? MAG_MAX : m[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sedt_line_store.sv =====
// line store memory: one word per column holds the luma of the two rows above
// depends on nothing; registered read, one write and one read port
`default_nettype none

module sedt_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sedt_cell.sv =====
// window cell: holds one column of luma and hands it to the next cell
// depends on sedt_pkg
`default_nettype none

module sedt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          shift,
  input  wire sedt_pkg::col_t col_in,
  output sedt_pkg::col_t     col_out
);

  import sedt_pkg::*;

  col_t col_q;

  // column register, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_out = col_q;

endmodule

`default_nettype wire

// ===== rtl/sobel_edge_threshold.sv =====
// Channel  Dir  Payload                                        Handshake
// s        in   tdata pixel_in, tuser frame_start              s_tvalid/s_tready
// m        out  tdata pixel_out,out_col,out_row, tlast done    m_tvalid/m_tready
// cfg      in   cfg_index, cfg_data                            cfg_valid/cfg_ready
// One pixel per clock while s_tready is high; results are registered in each stage and in out_q.
// The rate is set by the line store's single read and write port, used once per pixel.
// Reset clears counters, window cells and config; line store content is not cleared.
// s_tready drops only while the output skid register is full.
// cfg_ready is always high.
//
// top level of the sobel edge block; depends on sedt_pkg, sedt_cell,
// sedt_line_store and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // slave stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sedt_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] pixel_in
  input  wire logic [0:0]                       s_tuser,  // [0] frame_start
  // master stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sedt_pkg::M_TDATA_W-1:0]        m_tdata,  // [31:0] pixel_out,
                                                          // [41:32] out_col,
                                                          // [53:42] out_row, zero pad
  output logic                                  m_tlast,  // frame_done
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sedt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sedt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sedt_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int RST_W  = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int RST_H  = (4096 > MAX_HEIGHT) ? MAX_HEIGHT : 4096;
  localparam int WORD_W = 2 * LUMA_W;
  localparam int PROD_W = SUM_W + RECIP_W;

  // configuration registers
  logic [7:0]       thr;
  logic             sketch;
  logic [COL_W-1:0] wlast;
  logic [ROW_W-1:0] hlast;
  logic [31:0]      w_req;
  logic [31:0]      h_req;
  logic [31:0]      w_sat;
  logic [31:0]      h_sat;

  assign cfg_ready = 1'b1;
  assign w_req = 32'(cfg_data[10:0]);
  assign h_req = 32'(cfg_data[12:0]);

  // saturate the frame size into the supported range
  always_comb begin
    w_sat = w_req;
    if (w_req < 32'd3) begin
      w_sat = 32'd3;
    end else if (w_req > 32'(MAX_WIDTH)) begin
      w_sat = 32'(MAX_WIDTH);
    end
    h_sat = h_req;
    if (h_req < 32'd3) begin
      h_sat = 32'd3;
    end else if (h_req > 32'(MAX_HEIGHT)) begin
      h_sat = 32'(MAX_HEIGHT);
    end
  end

  // register write decoder
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THR_DEFAULT;
      sketch <= 1'b0;
      wlast  <= COL_W'(RST_W - 1);
      hlast  <= ROW_W'(RST_H - 1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD:    thr    <= (cfg_data[7:0] == 8'd0) ? THR_DEFAULT : cfg_data[7:0];
        REG_SKETCH_MODE:  sketch <= cfg_data[0];
        REG_FRAME_WIDTH:  wlast  <= COL_W'(w_sat - 32'd1);
        REG_FRAME_HEIGHT: hlast  <= ROW_W'(h_sat - 32'd1);
        default: ;
      endcase
    end
  end

  // pipeline enable: everything advances unless the skid register is full
  logic en;
  logic acc;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign acc      = s_tvalid && en;

  // raster position of the incoming request
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] acc_x;
  logic [ROW_W-1:0] acc_y;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             acc_done;

  always_comb begin
    acc_x    = (s_tuser[0] || col > wlast) ? '0 : col;
    acc_y    = (s_tuser[0] || row > hlast) ? '0 : row;
    acc_done = (acc_x == wlast) && (acc_y == hlast);
    col_next = acc_x + COL_W'(1);
    row_next = acc_y;
    if (acc_x == wlast) begin
      col_next = '0;
      row_next = (acc_y == hlast) ? '0 : acc_y + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // stage 1: weighted byte sum
  logic [SUM_W-1:0] acc_sum;

  assign acc_sum = (s_tdata[31:24] == 8'd0) ? '0 :
                   SUM_W'(s_tdata[7:0])   * SUM_W'(LUMA_W_LO)
                 + SUM_W'(s_tdata[15:8])  * SUM_W'(LUMA_W_MID)
                 + SUM_W'(s_tdata[23:16]) * SUM_W'(LUMA_W_HI);

  logic             s1_valid;
  logic [SUM_W-1:0] s1_sum;
  logic [COL_W-1:0] s1_x;
  logic [ROW_W-1:0] s1_y;
  logic             s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum  <= acc_sum;
      s1_x    <= acc_x;
      s1_y    <= acc_y;
      s1_done <= acc_done;
    end
  end

  // stage 2: luma by reciprocal multiply, line store read lands here
  logic [PROD_W-1:0] luma_prod;
  assign luma_prod = PROD_W'(s1_sum) * PROD_W'(LUMA_RECIP);

  logic              s2_valid;
  logic [LUMA_W-1:0] s2_luma;
  logic [COL_W-1:0]  s2_x;
  logic [ROW_W-1:0]  s2_y;
  logic              s2_done;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_word;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] s2_word;
  logic [WORD_W-1:0] wr_word;
  logic [LUMA_W-1:0] s2_top;
  logic [LUMA_W-1:0] s2_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  // forward the write of the request ahead when both hit the same column
  always_ff @(posedge clk) begin
    if (en) begin
      s2_luma  <= luma_prod[RECIP_SHIFT +: LUMA_W];
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_done  <= s1_done;
      fwd_hit  <= s2_valid && (s2_x == s1_x);
      fwd_word <= wr_word;
    end
  end

  assign s2_word = fwd_hit ? fwd_word : rd_word;
  assign s2_top  = s2_word[WORD_W-1 -: LUMA_W];
  assign s2_mid  = s2_word[LUMA_W-1:0];
  assign wr_word = {s2_mid, s2_luma};

  sedt_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W),
    .DATA_W (WORD_W)
  ) u_lines (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (s1_x),
    .rd_data (rd_word),
    .wr_en   (en && s2_valid),
    .wr_addr (s2_x),
    .wr_data (wr_word)
  );

  // window chain: cell 1 holds column x-1, cell 0 holds column x-2
  col_t cur_col;
  col_t c1_col;
  col_t c0_col;
  logic win_shift;

  assign cur_col   = '{top: s2_top, mid: s2_mid, bot: s2_luma};
  assign win_shift = en && s2_valid;

  sedt_cell u_cell1 (
    .clk     (clk),
    .rst     (rst),
    .shift   (win_shift),
    .col_in  (cur_col),
    .col_out (c1_col)
  );

  sedt_cell u_cell0 (
    .clk     (clk),
    .rst     (rst),
    .shift   (win_shift),
    .col_in  (c1_col),
    .col_out (c0_col)
  );

  // stage 3: gradient magnitude of interior pixels
  logic             s2_emit;
  logic [COL_W-1:0] s2_xm1;
  logic [ROW_W-1:0] s2_ym1;

  assign s2_emit = s2_valid && (s2_x >= COL_W'(2)) && (s2_y >= ROW_W'(2));
  assign s2_xm1  = s2_x - COL_W'(1);
  assign s2_ym1  = s2_y - ROW_W'(1);

  logic                 s3_valid;
  logic [7:0]           s3_mag;
  logic [OUT_COL_W-1:0] s3_col;
  logic [OUT_ROW_W-1:0] s3_row;
  logic                 s3_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag  <= sobel_mag(c0_col, c1_col, cur_col);
      s3_col  <= OUT_COL_W'(s2_xm1);
      s3_row  <= OUT_ROW_W'(s2_ym1);
      s3_done <= s2_done;
    end
  end

  // threshold and color
  res_t       res;
  logic [7:0] grey;

  always_comb begin
    grey      = sketch ? MAG_MAX - s3_mag : s3_mag;
    res.row   = s3_row;
    res.col   = s3_col;
    res.done  = s3_done;
    if (s3_mag > thr) begin
      res.pixel = PIX_OPAQUE | {8'h00, grey, grey, grey};
    end else begin
      res.pixel = sketch ? PIX_WHITE : PIX_BLACK;
    end
  end

  // output register with skid stage
  logic new_res;
  res_t out_q;
  res_t skid_q;
  logic out_valid;

  assign new_res = en && s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= new_res;
      end
    end else if (new_res) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (new_res) begin
        out_q <= res;
      end
    end else if (new_res) begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_q.row, out_q.col, out_q.pixel};
  assign m_tlast  = out_q.done;

  // checks
  `SEDT_ASSERT(a_skid_has_out, !skid_valid || out_valid)
  `SEDT_ASSERT_NEXT(a_skid_from_stall, !skid_valid, !skid_valid || $past(out_valid && !m_tready))
  `SEDT_ASSERT(a_pos_in_frame, !acc || (acc_x <= wlast && acc_y <= hlast))

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for sobel_edge_threshold: drives ABGR pixel streams and
// register writes, predicts every edge result and compares it with the output stream
// depends on sedt_pkg and the sobel_edge_threshold rtl
`default_nettype none

module testbench;
  import sedt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 4096;
  localparam int ITEMS          = 750;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TIMEOUT_CYCLES = 250000;
  localparam int TALL_PHASE     = 2;
  localparam int TALL_ROWS      = 60;
  localparam int COL_LSB        = PIX_W;
  localparam int ROW_LSB        = PIX_W + OUT_COL_W;

  localparam logic [CFG_IDX_W-1:0] REG_IDX_LAST     = '1;
  localparam logic [PIX_W-1:0]     ZERO_ALPHA_WHITE = 32'h00FFFFFF;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_t;

  // one line of the directed stimulus table
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      pix;
    logic                  sof;
    logic                  typed;
    res_t                  want;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state of the edge filter
  logic [7:0]            luma_above [0:MAX_W-1];
  logic [7:0]            luma_two_above [0:MAX_W-1];
  logic [7:0]            win [0:5];
  int                    col_pos;
  int                    row_pos;
  logic [7:0]            thr_reg;
  logic                  sketch_reg;
  logic [10:0]           width_reg;
  logic [12:0]           height_reg;

  res_t                  expected_edges [$];
  directed_row_t         directed_rows [$];
  int                    mismatches = 0;
  int                    burst_left = 0;

  ready_mode_t           ready_mode = READY_ALWAYS;
  int unsigned           ready_left = 0;
  logic [1:0]            ready_tick = '0;

  sobel_edge_threshold #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // weighted luma, zero alpha gives black
  function automatic int pixel_luma(input logic [PIX_W-1:0] p);
    int sum;
    if (p[31:24] == 8'h00) return 0;
    sum = int'(p[7:0]) * LUMA_W_LO + int'(p[15:8]) * LUMA_W_MID + int'(p[23:16]) * LUMA_W_HI;
    return sum / 1000;
  endfunction

  // advance the filter by one pixel, returns 1 when an interior result comes out
  function automatic bit predict_edge_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                                            output res_t r);
    int w, h, thr, x, y, lum, top, mid, gx, gy, mag, g;
    bit hit;
    w = int'(width_reg);
    if (w < 3) w = 3;
    else if (w > MAX_W) w = MAX_W;
    h = int'(height_reg);
    if (h < 3) h = 3;
    else if (h > MAX_H) h = MAX_H;
    thr = (thr_reg == 8'd0) ? int'(THR_DEFAULT) : int'(thr_reg);
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    lum = pixel_luma(pix);
    top = int'(luma_two_above[x]);
    mid = int'(luma_above[x]);
    hit = (x >= 2) && (y >= 2);
    r = '0;
    if (hit) begin
      gx = (top + 2 * mid + lum) - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
      gy = (int'(win[2]) + 2 * int'(win[5]) + lum) - (int'(win[0]) + 2 * int'(win[3]) + top);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
      if (mag > thr) begin
        g = sketch_reg ? int'(MAG_MAX) - mag : mag;
        r.pixel = PIX_OPAQUE | {8'h00, 8'(g), 8'(g), 8'(g)};
      end else begin
        r.pixel = sketch_reg ? PIX_WHITE : PIX_BLACK;
      end
      r.col  = OUT_COL_W'(x - 1);
      r.row  = OUT_ROW_W'(y - 1);
      r.done = (x == w - 1) && (y == h - 1);
    end
    // slide the window one column and update both line stores
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = 8'(top);
    win[4] = 8'(mid);
    win[5] = 8'(lum);
    luma_two_above[x] = 8'(mid);
    luma_above[x] = 8'(lum);
    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return hit;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data,
                                  input logic [PIX_W-1:0] pix, input logic sof,
                                  input logic typed, input res_t want);
    directed_row_t row;
    row.kind  = kind;
    row.idx   = idx;
    row.data  = data;
    row.pix   = pix;
    row.sof   = sof;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // random register values, extremes often
  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    logic [7:0] t;
    case ($urandom_range(0, 5))
      0: t = 8'd0;
      1: t = 8'd1;
      2: t = 8'd255;
      default: t = 8'($urandom_range(2, 254));
    endcase
    return {5'($urandom), t};
  endfunction

  // mix of extremes, noise and smooth opaque areas around a phase base level
  function automatic logic [PIX_W-1:0] random_pixel(input logic [7:0] base);
    case ($urandom_range(0, 9))
      0: return PIX_BLACK;
      1: return PIX_WHITE;
      2: return {8'h00, 24'($urandom)};
      3, 4, 5: return $urandom;
      default: return {8'($urandom_range(1, 255)), base + 8'($urandom_range(0, 7)),
                       base + 8'($urandom_range(0, 7)), base + 8'($urandom_range(0, 7))};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // wait until every predicted result has arrived and the pipeline is empty
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // caller lowers cfg_valid after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_THRESHOLD:    thr_reg = data[7:0];
      REG_SKETCH_MODE:  sketch_reg = data[0];
      REG_FRAME_WIDTH:  width_reg = data[10:0];
      REG_FRAME_HEIGHT: height_reg = data[12:0];
      default: ;
    endcase
  endtask

  // one pixel request, with bursts and random gaps on the sender side
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                            input logic typed, input res_t want);
    res_t predicted;
    bit   hit;
    int   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hit = predict_edge_pixel(pix, sof, predicted);
    if (typed) expected_edges.push_back(want);
    else if (hit) expected_edges.push_back(predicted);
  endtask

  // reconfigure while idle, then stream one block of pixels from a new frame
  task automatic run_phase(input logic [CFG_DATA_W-1:0] thr_d, input logic [CFG_DATA_W-1:0] sk_d,
                           input logic [CFG_DATA_W-1:0] w_d, input logic [CFG_DATA_W-1:0] h_d,
                           input int count);
    logic [7:0] base;
    base = 8'($urandom);
    drain_results();
    write_reg(REG_THRESHOLD, thr_d);
    write_reg(REG_SKETCH_MODE, sk_d);
    write_reg(REG_FRAME_WIDTH, w_d);
    write_reg(REG_FRAME_HEIGHT, h_d);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_IDX_LAST), int'(REG_FRAME_HEIGHT) + 1)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    for (int k = 0; k < count; k++)
      send_pixel(random_pixel(base), (k == 0) || ($urandom_range(0, 63) == 0), 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("unexpected result, pixel", m_tdata[PIX_W-1:0], '0);
      end else begin
        want = expected_edges.pop_front();
        if (m_tdata[PIX_W-1:0] !== want.pixel)
          report_mismatch($sformatf("pixel_out at row %0d col %0d", want.row, want.col),
                          m_tdata[PIX_W-1:0], want.pixel);
        if (m_tdata[COL_LSB +: OUT_COL_W] !== want.col)
          report_mismatch("out_col", 32'(m_tdata[COL_LSB +: OUT_COL_W]), 32'(want.col));
        if (m_tdata[ROW_LSB +: OUT_ROW_W] !== want.row)
          report_mismatch("out_row", 32'(m_tdata[ROW_LSB +: OUT_ROW_W]), 32'(want.row));
        if (m_tlast !== want.done)
          report_mismatch($sformatf("frame_done at row %0d col %0d", want.row, want.col),
                          32'(m_tlast), 32'(want.done));
      end
    end
  end

  // receiver backpressure, mode picked at random and held for a random stretch
  always @(posedge clk) begin
    ready_tick <= ready_tick + 2'd1;
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
      ready_left <= $urandom_range(16, 160);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
      default:      m_tready <= (ready_tick == 2'd0);
    endcase
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    res_t                  want;
    logic [PIX_W-1:0]      pix;
    logic [CFG_DATA_W-1:0] w_d;
    logic [CFG_DATA_W-1:0] h_d;
    int                    w_eff;
    int                    h_eff;
    int                    count;
    int                    random_items;

    // model reset state
    for (int i = 0; i < MAX_W; i++) begin
      luma_above[i] = '0;
      luma_two_above[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    thr_reg    = THR_DEFAULT;
    sketch_reg = 1'b0;
    width_reg  = 11'(MAX_W);
    height_reg = 13'(MAX_H);

    // directed table: 3x3 frames, flat white then a hard vertical edge in sketch mode
    want = '0;
    add_row(ROW_REG, REG_FRAME_WIDTH, 13'd3, '0, 1'b0, 1'b0, want);
    add_row(ROW_REG, REG_FRAME_HEIGHT, 13'd3, '0, 1'b0, 1'b0, want);
    want.pixel = PIX_BLACK;
    want.col   = 10'd1;
    want.row   = 12'd1;
    want.done  = 1'b1;
    for (int i = 0; i < 9; i++)
      add_row(ROW_PIXEL, '0, '0, PIX_WHITE, i == 0, i == 8, want);
    add_row(ROW_REG, REG_SKETCH_MODE, 13'd1, '0, 1'b0, 1'b0, want);
    add_row(ROW_REG, REG_IDX_LAST, '1, '0, 1'b0, 1'b0, want);
    // dark left side mixes zero alpha with opaque black, next frame starts by wrapping
    want.pixel = PIX_OPAQUE;
    for (int i = 0; i < 9; i++) begin
      if (i % 3 == 2) pix = PIX_WHITE;
      else if (i % 3 == 1) pix = PIX_OPAQUE;
      else if (i == 3) pix = ZERO_ALPHA_WHITE;
      else pix = PIX_BLACK;
      add_row(ROW_PIXEL, '0, '0, pix, 1'b0, i == 8, want);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_REG) drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        if (i == directed_rows.size() - 1 || directed_rows[i+1].kind != ROW_REG)
          cfg_valid <= 1'b0;
      end else begin
        send_pixel(directed_rows[i].pix, directed_rows[i].sof, directed_rows[i].typed,
                   directed_rows[i].want);
      end
    end

    // random phases, small frames mostly, one tall phase at or above the height limit
    random_items = 0;
    for (int phase = 0; random_items < ITEMS; phase++) begin
      if (phase == TALL_PHASE) begin
        h_d = $urandom_range(0, 1) ? CFG_DATA_W'(MAX_H) : '1;
        random_items += 3 * TALL_ROWS;
        run_phase(pick_threshold(), CFG_DATA_W'($urandom), 13'd2, h_d, 3 * TALL_ROWS);
      end else begin
        w_eff = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        h_eff = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        w_d = {2'($urandom), 11'(w_eff)};
        h_d = 13'(h_eff);
        if (w_eff < 3) w_eff = 3;
        if (h_eff < 3) h_eff = 3;
        count = $urandom_range(1, 3) * w_eff * h_eff + $urandom_range(0, 2 * w_eff);
        random_items += count;
        run_phase(pick_threshold(), CFG_DATA_W'($urandom), w_d, h_d, count);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
